// ----- rtl/core/dcb_pkg.sv -----
// Shared types, constants and interval helpers of the diatonic chord builder.
package dcb_pkg;

	localparam int MAX_NOTES = 6;
	localparam int IDX_W = $clog2(MAX_NOTES);
	localparam int CNT_W = $clog2(MAX_NOTES + 1);
	localparam int SLOTS = 8;

	localparam logic [6:0] ROOT_BASE = 7'd48;

	localparam logic [1:0] REG_KEY_TONIC = 2'd0;
	localparam logic [1:0] REG_SCALE_MODE = 2'd1;
	localparam logic [1:0] REG_EXT_PRESET = 2'd2;
	localparam logic [1:0] REG_STICK_MAP = 2'd3;

	localparam logic [1:0] MAP_DIATONIC = 2'd0;
	localparam logic [1:0] MAP_TRANSFORM = 2'd1;
	localparam logic [1:0] MAP_RECIPE = 2'd2;

	localparam logic [1:0] EXT_BASIC = 2'd0;
	localparam logic [1:0] EXT_SEVENTH = 2'd1;
	localparam logic [1:0] EXT_NINTH = 2'd2;
	localparam logic [1:0] EXT_SIXNINE = 2'd3;

	localparam logic [3:0] Z_CENTER = 4'd0;
	localparam logic [3:0] Z_UP = 4'd1;
	localparam logic [3:0] Z_DOWN = 4'd2;
	localparam logic [3:0] Z_LEFT = 4'd3;
	localparam logic [3:0] Z_RIGHT = 4'd4;
	localparam logic [3:0] Z_UP_RIGHT = 4'd5;
	localparam logic [3:0] Z_UP_LEFT = 4'd6;
	localparam logic [3:0] Z_DOWN_RIGHT = 4'd7;
	localparam logic [3:0] Z_DOWN_LEFT = 4'd8;

	localparam logic [3:0] MAJOR_STEPS [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
	localparam logic [3:0] MINOR_STEPS [7] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};

	// chromatic recipes per zone, negative entries are unused
	localparam logic signed [4:0] RECIPES [9][4] = '{
		'{5'sd0, 5'sd4, 5'sd7, -5'sd1}, '{5'sd0, 5'sd3, 5'sd7, -5'sd1},
		'{5'sd0, 5'sd4, 5'sd7, 5'sd9}, '{5'sd0, 5'sd3, 5'sd6, -5'sd1},
		'{5'sd0, 5'sd4, 5'sd7, 5'sd10}, '{5'sd0, 5'sd4, 5'sd7, 5'sd11},
		'{5'sd0, 5'sd4, 5'sd8, -5'sd1}, '{5'sd0, 5'sd3, 5'sd7, 5'sd10},
		'{5'sd0, 5'sd3, 5'sd7, 5'sd9}
	};

	typedef struct packed {
		logic [2:0] degree;
		logic [3:0] zone;
		logic       force_dominant;
	} in_word_t;

	typedef struct packed {
		logic [6:0] note;
		logic [2:0] note_index;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [3:0] key_tonic;
		logic       scale_mode;
		logic [1:0] extension_preset;
		logic [1:0] stick_map;
	} cfg_t;

	typedef struct packed {
		logic [MAX_NOTES-1:0][6:0] notes;
		logic [CNT_W-1:0]          cnt;
	} chord_t;

	typedef struct packed {
		logic       en;
		logic [4:0] iv;
	} cand_t;

	function automatic logic [3:0] step(input logic mode, input logic [2:0] a);
		step = mode ? MINOR_STEPS[a] : MAJOR_STEPS[a];
	endfunction

	// upward distance from scale step a to a+k, 0 becomes 12
	function automatic logic [3:0] span(input logic mode, input logic [2:0] a,
			input logic [2:0] k);
		logic [3:0] s;
		logic [4:0] d;
		s = {1'b0, a} + {1'b0, k};
		if (s >= 4'd7)
			s = s - 4'd7;
		d = 5'd12 + {1'b0, step(mode, s[2:0])} - {1'b0, step(mode, a)};
		if (d >= 5'd12)
			d = d - 5'd12;
		span = (d == 5'd0) ? 4'd12 : d[3:0];
	endfunction

	function automatic cand_t mk(input logic [4:0] v, input logic safe);
		mk.iv = v;
		mk.en = !(safe && (v == 5'd0 || v == 5'd1 || v == 5'd13));
	endfunction

endpackage

// ----- rtl/core/dcb_build.sv -----
// Chord construction: candidate interval list, then pitch-class filter and note limit.
module dcb_build import dcb_pkg::*; (
	input  in_word_t req,
	input  cfg_t     cfg,
	output chord_t   chord
);

	logic [2:0] d, d2;
	logic [3:0] z;
	logic [4:0] pc_sum;
	logic [6:0] root;
	logic [3:0] i2, i3, i4, i5, i6, i7;
	logic [4:0] i9, t5;
	logic       dom, maj;
	cand_t      list [SLOTS];
	logic [3:0] n;
	logic [11:0] mask;
	logic [4:0] pc;
	logic [CNT_W-1:0] cnt;

	always_comb begin
		d = (req.degree == 3'd7) ? 3'd0 : req.degree;
		z = (req.zone > Z_DOWN_LEFT) ? Z_CENTER : req.zone;
		d2 = (d >= 3'd5) ? d - 3'd5 : d + 3'd2;
		pc_sum = {1'b0, cfg.key_tonic} + {1'b0, step(cfg.scale_mode, d)};
		if (pc_sum >= 5'd12)
			pc_sum = pc_sum - 5'd12;
		if (pc_sum >= 5'd12)
			pc_sum = pc_sum - 5'd12;
		root = ROOT_BASE + {3'd0, pc_sum[3:0]};

		i2 = span(cfg.scale_mode, d, 3'd1);
		i3 = span(cfg.scale_mode, d, 3'd2);
		i4 = span(cfg.scale_mode, d, 3'd3);
		i5 = span(cfg.scale_mode, d, 3'd4);
		i6 = span(cfg.scale_mode, d, 3'd5);
		i7 = span(cfg.scale_mode, d, 3'd6);
		i9 = {1'b0, i2} + 5'd12;
		t5 = {1'b0, i3} + {1'b0, span(cfg.scale_mode, d2, 3'd2)};
		dom = (i3 == 4'd4) && (i7 == 4'd10);
		maj = (i3 == 4'd4);

		for (int s = 0; s < SLOTS; s++)
			list[s] = '0;
		list[0] = mk(5'd0, 1'b0);
		n = 4'd1;

		if (req.force_dominant) begin
			list[n[2:0]] = mk(5'd4, 1'b0); n = n + 4'd1;
			list[n[2:0]] = mk(5'd7, 1'b0); n = n + 4'd1;
			list[n[2:0]] = mk(5'd10, 1'b0); n = n + 4'd1;
			if (z == Z_UP || z == Z_UP_RIGHT || z == Z_DOWN_RIGHT) begin
				list[n[2:0]] = mk(5'd14, 1'b0); n = n + 4'd1;
			end
		end else if (cfg.stick_map == MAP_TRANSFORM) begin
			case (z)
				Z_UP: begin
					list[n[2:0]] = mk(maj ? 5'd3 : 5'd4, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(t5, 1'b0); n = n + 4'd1;
				end
				Z_RIGHT: begin
					list[n[2:0]] = mk({1'b0, i3}, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(t5, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(maj ? 5'd11 : 5'd10, 1'b0); n = n + 4'd1;
				end
				Z_DOWN: begin
					list[n[2:0]] = mk(5'd5, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(5'd7, 1'b0); n = n + 4'd1;
				end
				Z_LEFT: begin
					list[n[2:0]] = mk(5'd3, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(maj ? 5'd7 : 5'd6, 1'b0); n = n + 4'd1;
				end
				Z_UP_RIGHT: begin
					list[n[2:0]] = mk(5'd4, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(5'd7, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(5'd10, 1'b0); n = n + 4'd1;
				end
				Z_DOWN_RIGHT: begin
					list[n[2:0]] = mk({1'b0, i3}, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(t5, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(5'd14, 1'b0); n = n + 4'd1;
				end
				Z_DOWN_LEFT: begin
					if (maj) begin
						list[n[2:0]] = mk(5'd4, 1'b0); n = n + 4'd1;
						list[n[2:0]] = mk(5'd7, 1'b0); n = n + 4'd1;
						list[n[2:0]] = mk(5'd9, 1'b0); n = n + 4'd1;
					end else begin
						list[n[2:0]] = mk(5'd2, 1'b0); n = n + 4'd1;
						list[n[2:0]] = mk(5'd7, 1'b0); n = n + 4'd1;
					end
				end
				Z_UP_LEFT: begin
					list[n[2:0]] = mk({1'b0, i3}, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(t5 + 5'd1, 1'b0); n = n + 4'd1;
				end
				default: begin
					list[n[2:0]] = mk({1'b0, i3}, 1'b0); n = n + 4'd1;
					list[n[2:0]] = mk(t5, 1'b0); n = n + 4'd1;
				end
			endcase
		end else if (cfg.stick_map == MAP_RECIPE) begin
			for (int k = 1; k < 4; k++) begin
				list[k] = mk(RECIPES[z][k], 1'b0);
				list[k].en = !RECIPES[z][k][4];
			end
		end else begin
			case (z)
				Z_DOWN_LEFT: begin
					list[n[2:0]] = mk({1'b0, i2}, 1'b1); n = n + 4'd1;
					list[n[2:0]] = mk({1'b0, i5}, 1'b1); n = n + 4'd1;
				end
				Z_LEFT: begin
					list[n[2:0]] = mk({1'b0, i4}, 1'b1); n = n + 4'd1;
					list[n[2:0]] = mk({1'b0, i5}, 1'b1); n = n + 4'd1;
				end
				Z_UP_LEFT: begin
					list[n[2:0]] = mk({1'b0, i4}, 1'b1); n = n + 4'd1;
					list[n[2:0]] = mk({1'b0, i5}, 1'b1); n = n + 4'd1;
					list[n[2:0]] = mk({1'b0, i7}, 1'b1); n = n + 4'd1;
				end
				default: begin
					list[n[2:0]] = mk({1'b0, i3}, 1'b1); n = n + 4'd1;
					list[n[2:0]] = mk({1'b0, i5}, 1'b1); n = n + 4'd1;
					case (z)
						Z_UP: begin
							list[n[2:0]] = mk(i9, 1'b1); n = n + 4'd1;
						end
						Z_UP_RIGHT: begin
							list[n[2:0]] = mk({1'b0, i6}, 1'b1); n = n + 4'd1;
							list[n[2:0]] = mk(i9, 1'b1); n = n + 4'd1;
						end
						Z_DOWN: begin
							list[n[2:0]] = mk({1'b0, i6}, 1'b1); n = n + 4'd1;
						end
						Z_RIGHT: begin
							list[n[2:0]] = mk({1'b0, dom ? i6 : i7}, 1'b1); n = n + 4'd1;
						end
						Z_DOWN_RIGHT: begin
							list[n[2:0]] = mk({1'b0, dom ? i6 : i7}, 1'b1); n = n + 4'd1;
							list[n[2:0]] = mk(i9, 1'b1); n = n + 4'd1;
						end
						default: ;
					endcase
				end
			endcase
			case (cfg.extension_preset)
				EXT_SEVENTH: begin
					if (!dom) begin
						list[n[2:0]] = mk({1'b0, i7}, 1'b1); n = n + 4'd1;
					end
				end
				EXT_NINTH: begin
					if (!dom) begin
						list[n[2:0]] = mk({1'b0, i7}, 1'b1); n = n + 4'd1;
					end
					list[n[2:0]] = mk(i9, 1'b1); n = n + 4'd1;
				end
				EXT_SIXNINE: begin
					list[n[2:0]] = mk({1'b0, i6}, 1'b1); n = n + 4'd1;
					list[n[2:0]] = mk(i9, 1'b1); n = n + 4'd1;
				end
				default: ;
			endcase
		end

		// keep each pitch class once, up to the note limit
		mask = '0;
		cnt = '0;
		chord.notes = '0;
		for (int s = 0; s < SLOTS; s++) begin
			pc = list[s].iv;
			if (pc >= 5'd12)
				pc = pc - 5'd12;
			if (pc >= 5'd12)
				pc = pc - 5'd12;
			if (list[s].en && !mask[pc[3:0]]) begin
				mask[pc[3:0]] = 1'b1;
				if (cnt < CNT_W'(MAX_NOTES)) begin
					chord.notes[cnt[IDX_W-1:0]] = root + {2'd0, list[s].iv};
					cnt = cnt + 1'b1;
				end
			end
		end
		chord.cnt = cnt;
	end

endmodule

// ----- rtl/core/diatonic_chord_builder_core.sv -----
// Top level of the diatonic chord builder: config registers, request register, note buffer.
// A request word is registered, its chord is built combinationally and loaded into a note
// buffer, and the notes then leave one word per cycle while out_ready is high, root first,
// with last set on the final note. A chord holds 1 to 6 notes; the next request is taken
// while the current chord drains and its chord follows the last note with no gap.
// With the note buffer idle, a request passes the request register and then the note
// buffer before its root note is offered.
module diatonic_chord_builder_core import dcb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	cfg_t             cfg_q;
	in_word_t         req_s1;
	logic             vld_s1;
	chord_t           chord;
	logic [MAX_NOTES-1:0][6:0] notes_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             buf_v_q;
	logic             take, is_last, buf_free, load;

	dcb_build u_build (
		.req   (req_s1),
		.cfg   (cfg_q),
		.chord (chord)
	);

	assign is_last = (CNT_W'(idx_q) + 1'b1) == cnt_q;
	assign take = buf_v_q && out_ready;
	assign buf_free = !buf_v_q || (take && is_last);
	assign load = vld_s1 && buf_free;
	assign in_ready = !vld_s1 || buf_free;

	assign out_valid = buf_v_q;
	assign out_data.note = notes_q[idx_q];
	assign out_data.note_index = 3'(idx_q);
	assign out_data.last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_TONIC: cfg_q.key_tonic <= cfg_data;
				REG_SCALE_MODE: cfg_q.scale_mode <= cfg_data[0];
				REG_EXT_PRESET: cfg_q.extension_preset <= cfg_data[1:0];
				REG_STICK_MAP: cfg_q.stick_map <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			buf_v_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (load) begin
				buf_v_q <= 1'b1;
				idx_q <= '0;
			end else if (take) begin
				if (is_last)
					buf_v_q <= 1'b0;
				else
					idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			req_s1 <= in_data;
		if (load) begin
			notes_q <= chord.notes;
			cnt_q <= chord.cnt;
		end
	end

endmodule

// ----- tb/tb_diatonic_chord_builder_core.sv -----
// Testbench of diatonic_chord_builder_core: directed table plus random requests, checked by a predictor.
module tb_diatonic_chord_builder_core;
	import dcb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	diatonic_chord_builder_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the registers
	logic [3:0] key_q;
	logic mode_q;
	logic [1:0] preset_q;
	logic [1:0] map_q;

	out_word_t note_q[$];
	int mismatches;
	bit failed;
	bit hold_off;
	int unsigned stall_pct;
	// typed-in root of the directed row on offer, -1 when none
	int dir_exp;

	// chord under construction
	int tones[8];
	int n_tones;
	int root_pitch;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("** diatonic_chord_builder_core: FAILED **");
		$finish;
	end

	function automatic int scale_step(input int i);
		int maj[7] = '{0, 2, 4, 5, 7, 9, 11};
		int mnr[7] = '{0, 2, 3, 5, 7, 8, 10};
		scale_step = mode_q ? mnr[i % 7] : maj[i % 7];
	endfunction

	function automatic int interval(input int a, input int b);
		int d;
		d = (12 + scale_step(b) - scale_step(a)) % 12;
		interval = (d == 0) ? 12 : d;
	endfunction

	function automatic void add_tone(input int iv);
		int p;
		p = root_pitch + iv;
		for (int i = 0; i < n_tones; i++)
			if (tones[i] % 12 == p % 12)
				return;
		if (n_tones < MAX_NOTES)
			tones[n_tones++] = p;
	endfunction

	function automatic void add_safe(input int iv);
		if (iv == 0 || iv == 1 || iv == 13)
			return;
		add_tone(iv);
	endfunction

	task automatic predict_chord(input in_word_t w);
		int d, z, i2, i3, i4, i5, i6, i7, i9, t5;
		bit dom, maj;
		int rec[9][4] = '{'{0, 4, 7, -1}, '{0, 3, 7, -1}, '{0, 4, 7, 9}, '{0, 3, 6, -1},
			'{0, 4, 7, 10}, '{0, 4, 7, 11}, '{0, 4, 8, -1}, '{0, 3, 7, 10}, '{0, 3, 7, 9}};
		out_word_t o;
		d = w.degree % 7;
		z = (w.zone > 8) ? 0 : w.zone;
		root_pitch = (key_q + scale_step(d)) % 12 + 48;
		n_tones = 1;
		tones[0] = root_pitch;
		if (w.force_dominant) begin
			tones[1] = root_pitch + 4;
			tones[2] = root_pitch + 7;
			tones[3] = root_pitch + 10;
			n_tones = 4;
			if (z == 1 || z == 5 || z == 7)
				tones[n_tones++] = root_pitch + 14;
		end else if (map_q == MAP_TRANSFORM) begin
			n_tones = 0;
			i3 = interval(d, d + 2);
			t5 = i3 + interval(d + 2, d + 4);
			maj = (i3 == 4);
			add_tone(0);
			case (z)
				1: begin add_tone(maj ? 3 : 4); add_tone(t5); end
				4: begin add_tone(i3); add_tone(t5); add_tone(maj ? 11 : 10); end
				2: begin add_tone(5); add_tone(7); end
				3: begin add_tone(3); add_tone(maj ? 7 : 6); end
				5: begin add_tone(4); add_tone(7); add_tone(10); end
				7: begin add_tone(i3); add_tone(t5); add_tone(14); end
				8: begin
					if (maj) begin add_tone(4); add_tone(7); add_tone(9); end
					else begin add_tone(2); add_tone(7); end
				end
				6: begin add_tone(i3); add_tone(t5 + 1); end
				default: begin add_tone(i3); add_tone(t5); end
			endcase
		end else if (map_q == MAP_RECIPE) begin
			n_tones = 0;
			for (int k = 0; k < 4; k++)
				if (rec[z][k] >= 0)
					add_tone(rec[z][k]);
		end else begin
			i2 = interval(d, d + 1);
			i3 = interval(d, d + 2);
			i4 = interval(d, d + 3);
			i5 = interval(d, d + 4);
			i6 = interval(d, d + 5);
			i7 = interval(d, d + 6);
			i9 = i2 + 12;
			dom = (i3 == 4) && (i7 == 10);
			case (z)
				8: begin add_safe(i2); add_safe(i5); end
				3: begin add_safe(i4); add_safe(i5); end
				6: begin add_safe(i4); add_safe(i5); add_safe(i7); end
				default: begin
					add_safe(i3); add_safe(i5);
					case (z)
						1: add_safe(i9);
						5: begin add_safe(i6); add_safe(i9); end
						2: add_safe(i6);
						4: add_safe(dom ? i6 : i7);
						7: begin add_safe(dom ? i6 : i7); add_safe(i9); end
						default: ;
					endcase
				end
			endcase
			case (preset_q)
				EXT_SEVENTH: if (!dom) add_safe(i7);
				EXT_NINTH: begin if (!dom) add_safe(i7); add_safe(i9); end
				EXT_SIXNINE: begin add_safe(i6); add_safe(i9); end
				default: ;
			endcase
		end
		for (int k = 0; k < n_tones; k++) begin
			o.note = tones[k][6:0];
			o.note_index = k[2:0];
			o.last = (k + 1 == n_tones);
			note_q.push_back(o);
		end
	endtask

	// scoreboard, also feeds the predictor on each accepted request
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && in_valid && in_ready) begin
			predict_chord(in_data);
			if (dir_exp >= 0 && tones[0] != dir_exp) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("directed root: exp %0d, predicted %0d", dir_exp, tones[0]);
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (note_q.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: note %0d idx %0d last %0d",
						out_data.note, out_data.note_index, out_data.last);
			end else begin
				e = note_q.pop_front();
				if (e !== out_data) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp note %0d idx %0d last %0d, got %0d %0d %0d",
							e.note, e.note_index, e.last,
							out_data.note, out_data.note_index, out_data.last);
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// long hold-off starts while the sender is offering words
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (150) @(posedge clk);
		do
			@(posedge clk);
		while (!in_valid);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY_TONIC: key_q = val;
			REG_SCALE_MODE: mode_q = val[0];
			REG_EXT_PRESET: preset_q = val[1:0];
			default: map_q = val[1:0];
		endcase
	endtask

	task automatic set_all(input logic [3:0] k, input logic m, input logic [1:0] p,
			input logic [1:0] s);
		write_reg(REG_KEY_TONIC, k);
		write_reg(REG_SCALE_MODE, {3'b0, m});
		write_reg(REG_EXT_PRESET, {2'b0, p});
		write_reg(REG_STICK_MAP, {2'b0, s});
	endtask

	// send one word; returns at the edge where it was accepted
	task automatic send_word(input in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		while (note_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (note_q.size() != 0) begin
			$display("** diatonic_chord_builder_core: FAILED **");
			$finish;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic random_burst(input int count);
		in_word_t w;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			w.degree = 3'($urandom_range(7));
			w.zone = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
				4'($urandom_range(8));
			w.force_dominant = ($urandom_range(4) == 0);
			send_word(w);
			if (burst == 0) begin
				burst = $urandom_range(12);
				if ($urandom_range(1)) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(8)) @(posedge clk);
				end
			end else
				burst--;
		end
		in_valid <= 1'b0;
	endtask

	// directed table: degree, zone, force_dominant, expected root (-1 = predictor only)
	typedef struct {
		int deg;
		int zn;
		int fd;
		int root;
	} dir_row_t;

	dir_row_t dir_rows[20] = '{
		'{0, 0, 0, 48}, '{1, 1, 0, -1}, '{2, 2, 0, -1}, '{3, 3, 0, -1},
		'{4, 4, 0, 55}, '{5, 5, 0, -1}, '{6, 6, 0, 59}, '{4, 7, 0, -1},
		'{1, 8, 0, -1}, '{7, 0, 0, 48}, '{0, 15, 0, 48}, '{4, 1, 1, 55},
		'{2, 5, 1, -1}, '{6, 7, 1, -1}, '{3, 0, 1, 53}, '{6, 9, 1, -1},
		'{7, 2, 1, 48}, '{5, 3, 0, -1}, '{2, 4, 0, -1}, '{0, 8, 1, 48}
	};

	initial begin
		in_word_t w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_pct = 30;
		mismatches = 0;
		failed = 1'b0;
		dir_exp = -1;
		key_q = '0;
		mode_q = 1'b0;
		preset_q = '0;
		map_q = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset configuration
		foreach (dir_rows[i]) begin
			w.degree = 3'(dir_rows[i].deg);
			w.zone = 4'(dir_rows[i].zn);
			w.force_dominant = 1'(dir_rows[i].fd);
			dir_exp <= dir_rows[i].root;
			send_word(w);
		end
		in_valid <= 1'b0;
		dir_exp <= -1;
		drain();

		// sweep configurations, extremes included
		set_all(4'd11, 1'b1, EXT_SIXNINE, MAP_DIATONIC);
		random_burst(30);
		drain();
		set_all(4'd15, 1'b0, EXT_SEVENTH, MAP_TRANSFORM);
		random_burst(30);
		drain();
		set_all(4'd5, 1'b1, EXT_NINTH, MAP_RECIPE);
		random_burst(30);
		drain();
		set_all(4'd2, 1'b0, EXT_NINTH, 2'd3);
		random_burst(30);
		drain();
		stall_pct = 0;
		for (int ph = 0; ph < 8; ph++) begin
			set_all(4'($urandom_range(15)), 1'($urandom_range(1)), 2'($urandom_range(3)),
				2'($urandom_range(3)));
			stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(70);
			random_burst(25);
			drain();
		end

		if (!failed)
			$display("** diatonic_chord_builder_core: PASSED **");
		else
			$display("** diatonic_chord_builder_core: FAILED **");
		$finish;
	end

endmodule

// ----- diatonic_chord_builder_core.f -----
rtl/core/dcb_pkg.sv
rtl/core/dcb_build.sv
rtl/core/diatonic_chord_builder_core.sv
tb/tb_diatonic_chord_builder_core.sv
